@@ hw/rtl/sdgl_pkg.sv @@
// shared constants, types and register indexes for the signed decimal glyph layout block
// no dependencies; imported by signed_decimal_glyph_layout
`default_nettype none

package sdgl_pkg;

  localparam int VALUE_W        = 32;
  localparam int COORD_W        = 16;
  localparam int GLYPH_W        = 6;
  localparam int STYLE_W        = 2;
  localparam int WIDTH_W        = 8;
  localparam int FIXED_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int DIGIT_W        = 4;
  localparam int BCD_DIGITS     = 10;
  localparam int BCD_W          = BCD_DIGITS * DIGIT_W;
  localparam int MAX_DIGITS_DEF = 10;

  localparam logic [STYLE_W-1:0] STYLE_RST = 2'd0;
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 8'd16;
  localparam logic [FIXED_W-1:0] FIXED_RST = 4'd0;

  localparam logic [GLYPH_W-1:0] GLYPH_MINUS = 6'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_STYLE  = 2'd0,
    CFG_GLYPH_WIDTH  = 2'd1,
    CFG_FIXED_DIGITS = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_SETUP,
    S_EMIT
  } state_t;

  // first glyph of a set: style * 11
  function automatic logic [GLYPH_W-1:0] glyph_base(input logic [STYLE_W-1:0] style);
    logic [GLYPH_W-1:0] s;
    s = {{(GLYPH_W-STYLE_W){1'b0}}, style};
    return (s << 3) + (s << 1) + s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/signed_decimal_glyph_layout.sv @@
// signed decimal glyph layout: top level with bit-serial binary to bcd conversion and glyph emitter
// depends on sdgl_pkg
`default_nettype none

// Each accepted value is converted to decimal one magnitude bit per cycle in a shift-and-add-3
// register (S_CONV), then the leading zero digits are skipped one digit per cycle (S_SCAN),
// S_SETUP forms the starting x position, and then one glyph is loaded into the output
// register per cycle while out_ready allows: the digits least significant first, then a minus
// glyph for a negative value, with out_last on the final one. A new value is accepted as soon
// as the last glyph sits in the output register. Configuration writes are always accepted and
// take effect at once.
module signed_decimal_glyph_layout #(
  parameter int MAX_DIGITS = sdgl_pkg::MAX_DIGITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire signed [sdgl_pkg::VALUE_W-1:0]   in_value,
  input  wire signed [sdgl_pkg::COORD_W-1:0]   in_left_x,
  input  wire signed [sdgl_pkg::COORD_W-1:0]   in_top_y,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [sdgl_pkg::GLYPH_W-1:0]         out_glyph_index,
  output logic signed [sdgl_pkg::COORD_W-1:0]  out_pos_x,
  output logic signed [sdgl_pkg::COORD_W-1:0]  out_pos_y,
  output logic                                 out_last,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [sdgl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [sdgl_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import sdgl_pkg::*;

  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int LEN_W = $clog2(BCD_DIGITS + 1);
  localparam int BIT_W = $clog2(VALUE_W);

  state_t state_r, state_nxt;

  logic [STYLE_W-1:0] style_r;
  logic [WIDTH_W-1:0] width_r;
  logic [FIXED_W-1:0] fixed_r;

  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   scan_r, scan_nxt;
  logic [BIT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               neg_r, neg_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic [COORD_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [GLYPH_W-1:0] glyph_r, glyph_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt;
  logic [COORD_W-1:0] out_y_r, out_y_nxt;
  logic               last_r, last_nxt;

  logic [VALUE_W-1:0]       in_raw;
  logic [BCD_W-1:0]         bcd_adj;
  logic [CW-1:0]            count_calc;
  logic [CW-1:0]            factor;
  logic [WIDTH_W+CW-1:0]    prod;
  logic                     load;
  logic                     is_digit;
  logic [GLYPH_W-1:0]       base;

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_glyph_index = glyph_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;
  assign out_last        = last_r;

  assign in_raw = in_value;
  assign base   = glyph_base(style_r);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd_r;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd_r[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_r[k*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
  end

  // digit count, saturated to the number of places
  always_comb begin
    if (fixed_r != '0) begin
      if (int'(fixed_r) > MAX_DIGITS) begin
        count_calc = CW'(MAX_DIGITS);
      end else begin
        count_calc = CW'(fixed_r);
      end
    end else if (int'(len_r) > MAX_DIGITS) begin
      count_calc = CW'(MAX_DIGITS);
    end else begin
      count_calc = CW'(len_r);
    end
    factor = neg_r ? count_calc : count_calc - CW'(1);
    prod   = {{CW{1'b0}}, width_r} * {{WIDTH_W{1'b0}}, factor};
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    scan_nxt      = scan_r;
    bit_cnt_nxt   = bit_cnt_r;
    len_nxt       = len_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    glyph_nxt     = glyph_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    last_nxt      = last_r;
    load          = 1'b0;
    is_digit      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt     = in_raw[VALUE_W-1];
          mag_nxt     = in_raw[VALUE_W-1] ? (~in_raw + VALUE_W'(1)) : in_raw;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          x_nxt       = in_left_x;
          y_nxt       = in_top_y;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[VALUE_W-1]};
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BIT_W'(1);
        if (bit_cnt_r == BIT_W'(VALUE_W - 1)) begin
          scan_nxt  = {bcd_adj[BCD_W-2:0], mag_r[VALUE_W-1]};
          len_nxt   = LEN_W'(BCD_DIGITS);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (len_r > LEN_W'(1) && scan_r[BCD_W-1 -: DIGIT_W] == '0) begin
          scan_nxt = {scan_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          len_nxt  = len_r - LEN_W'(1);
        end else begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        count_nxt = count_calc;
        idx_nxt   = '0;
        pos_nxt   = x_r + COORD_W'(prod);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        load     = !out_valid_r || out_ready;
        is_digit = (idx_r < count_r);
        if (load) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pos_r;
          out_y_nxt     = y_r;
          pos_nxt       = pos_r - {{(COORD_W-WIDTH_W){1'b0}}, width_r};
          idx_nxt       = idx_r + CW'(1);
          if (is_digit) begin
            glyph_nxt = base + {{(GLYPH_W-DIGIT_W){1'b0}}, bcd_r[DIGIT_W-1:0]};
            last_nxt  = !neg_r && (idx_r == count_r - CW'(1));
            bcd_nxt   = {{DIGIT_W{1'b0}}, bcd_r[BCD_W-1:DIGIT_W]};
          end else begin
            glyph_nxt = base + GLYPH_MINUS;
            last_nxt  = 1'b1;
          end
          if (last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r <= STYLE_RST;
      width_r <= WIDTH_RST;
      fixed_r <= FIXED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GLYPH_STYLE:  style_r <= cfg_data[STYLE_W-1:0];
        CFG_GLYPH_WIDTH:  width_r <= cfg_data[WIDTH_W-1:0];
        CFG_FIXED_DIGITS: fixed_r <= cfg_data[FIXED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    bcd_r     <= bcd_nxt;
    scan_r    <= scan_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    len_r     <= len_nxt;
    neg_r     <= neg_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    pos_r     <= pos_nxt;
    count_r   <= count_nxt;
    idx_r     <= idx_nxt;
    glyph_r   <= glyph_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    last_r    <= last_nxt;
  end

  // accepted value starts conversion
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CONV))
    else $error("accepted transaction did not start conversion");

  // digit count stays within the places available
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (count_r >= CW'(1) && int'(count_r) <= MAX_DIGITS))
    else $error("digit count out of range");

  // emission index never passes the minus glyph
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (idx_r <= count_r))
    else $error("glyph index counter overran");

  // a glyph left waiting holds its place
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(glyph_r) && $stable(last_r)))
    else $error("waiting glyph changed");

endmodule

`default_nettype wire
